### sv/pcls_pkg.sv
// Shared constants, types and command encodings for the plate capacitor solver.
// Used by the controller, the datapath and the top level; no dependencies.
package pcls_pkg;

    localparam int GRID_SIZE = 512;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int POT_W     = 24;
    localparam int CFG_W     = 23;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [2:0] REG_TOP_ROW   = 3'd0;
    localparam logic [2:0] REG_BOT_ROW   = 3'd1;
    localparam logic [2:0] REG_FIRST_COL = 3'd2;
    localparam logic [2:0] REG_LAST_COL  = 3'd3;
    localparam logic [2:0] REG_HALF_V    = 3'd4;
    localparam logic [2:0] REG_SWEEPS    = 3'd5;
    localparam logic [2:0] REG_SCALE     = 3'd6;

    // Controller to datapath commands.
    typedef struct packed {
        logic              mem_rd;    // read the grid at rd_addr
        logic [ADDR_W-1:0] rd_addr;
        logic [2:0]        rd_tag;    // which operand slot the read fills
        logic              cell_wr;   // finish a relaxation step for cursor cell
        logic              init_wr;   // write init value for cursor cell
        logic              clear_wr;  // write zero to cursor cell after reset
        logic [IDX_W-1:0]  cur_row;
        logic [IDX_W-1:0]  cur_col;
        logic              calc;      // compute field outputs from loaded slots
    } t_cmd;

    localparam logic [2:0] TAG_UP    = 3'd0;
    localparam logic [2:0] TAG_DOWN  = 3'd1;
    localparam logic [2:0] TAG_LEFT  = 3'd2;
    localparam logic [2:0] TAG_RIGHT = 3'd3;
    localparam logic [2:0] TAG_CTR   = 3'd4;

endpackage

### sv/pcls_datapath.sv
// Datapath of the plate capacitor solver: grid memory, operand slots, relaxation
// and field arithmetic. Depends on pcls_pkg for widths and the command struct.
module pcls_datapath (
    input  logic                          i_clk,
    input  pcls_pkg::t_cmd                i_cmd,
    input  logic [8:0]                    i_top_row,
    input  logic [8:0]                    i_bot_row,
    input  logic [8:0]                    i_first_col,
    input  logic [8:0]                    i_last_col,
    input  logic [22:0]                   i_half_v,
    input  logic [15:0]                   i_scale,
    output logic signed [pcls_pkg::POT_W-1:0] o_pot,
    output logic signed [31:0]            o_fx,
    output logic signed [31:0]            o_fy
);
    localparam int AW = pcls_pkg::ADDR_W;
    localparam int PW = pcls_pkg::POT_W;

    logic signed [PW-1:0] r_mem [0:(1 << AW)-1];
    logic signed [PW-1:0] r_rdata;
    logic [2:0]           r_rtag;
    logic                 r_rvalid;
    logic signed [PW-1:0] r_up, r_down, r_left, r_right, r_ctr;

    logic [1:0]           kind;
    logic signed [PW-1:0] plate_v;
    logic signed [PW+1:0] sum4;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [PW-1:0] wr_data;
    logic signed [PW:0]   dx, dy;
    logic signed [PW+16:0] px, py;
    logic signed [PW+8:0]  sx, sy;
    logic signed [PW-1:0]  left_now, right_now, up_now, down_now;

    // Plate classification of the cursor cell: 1 positive, 2 negative.
    always_comb begin
        kind = 2'd0;
        if (i_cmd.cur_col >= i_first_col && i_cmd.cur_col <= i_last_col) begin
            if (i_cmd.cur_row == i_top_row) begin
                kind = 2'd1;
            end else if (i_cmd.cur_row == i_bot_row) begin
                kind = 2'd2;
            end
        end
        plate_v = (kind == 2'd1) ? $signed({1'b0, i_half_v}) : -$signed({1'b0, i_half_v});
    end

    // The last operand read lands in the same cycle as the write command.
    always_comb begin
        up_now    = (r_rvalid && r_rtag == pcls_pkg::TAG_UP)    ? r_rdata : r_up;
        down_now  = (r_rvalid && r_rtag == pcls_pkg::TAG_DOWN)  ? r_rdata : r_down;
        left_now  = (r_rvalid && r_rtag == pcls_pkg::TAG_LEFT)  ? r_rdata : r_left;
        right_now = (r_rvalid && r_rtag == pcls_pkg::TAG_RIGHT) ? r_rdata : r_right;
        sum4 = (PW+2)'(up_now) + (PW+2)'(down_now) + (PW+2)'(left_now) + (PW+2)'(right_now);
        wr_en   = i_cmd.cell_wr || i_cmd.init_wr || i_cmd.clear_wr;
        wr_addr = {i_cmd.cur_row, i_cmd.cur_col};
        if (i_cmd.clear_wr) begin
            wr_data = '0;
        end else if (kind != 2'd0) begin
            wr_data = plate_v;
        end else if (i_cmd.init_wr) begin
            wr_data = '0;
        end else begin
            wr_data = sum4[PW+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end
        r_rtag   <= i_cmd.rd_tag;
        r_rvalid <= i_cmd.mem_rd;
        if (r_rvalid) begin
            case (r_rtag)
                pcls_pkg::TAG_UP:    r_up    <= r_rdata;
                pcls_pkg::TAG_DOWN:  r_down  <= r_rdata;
                pcls_pkg::TAG_LEFT:  r_left  <= r_rdata;
                pcls_pkg::TAG_RIGHT: r_right <= r_rdata;
                default:             r_ctr   <= r_rdata;
            endcase
        end
    end

    // Field step: one 25x17 multiply per axis, then floor shift and saturate.
    always_comb begin
        dx = (PW+1)'(r_left) - (PW+1)'(r_right);
        dy = (PW+1)'(r_up) - (PW+1)'(r_down);
        px = (PW+17)'(dx) * $signed({1'b0, i_scale});
        py = (PW+17)'(dy) * $signed({1'b0, i_scale});
        sx = px[PW+16:8];
        sy = py[PW+16:8];
    end

    // The shifted product needs 33 bits, so both saturation limits can be reached.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            o_pot <= r_ctr;
            o_fx  <= (sx > 33'sd2147483647) ? 32'h7FFFFFFF :
                     (sx < -33'sd2147483648) ? 32'h80000000 : sx[31:0];
            o_fy  <= (sy > 33'sd2147483647) ? 32'h7FFFFFFF :
                     (sy < -33'sd2147483648) ? 32'h80000000 : sy[31:0];
        end
    end
endmodule

### sv/pcls_ctrl.sv
// Controller of the plate capacitor solver: command intake, sweep sequencing,
// grid initialization walk and result handshake. Depends on pcls_pkg.
module pcls_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [8:0]           i_row,
    input  logic [8:0]           i_col,
    input  logic [15:0]          i_sweeps,
    output pcls_pkg::t_cmd       o_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_done_mode,
    output logic                 o_zero_pot,
    output logic                 o_zero_field
);
    localparam int IW = pcls_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(pcls_pkg::GRID_SIZE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_step, n_step;
    logic [IW-1:0] r_row, n_row, r_col, n_col;
    logic [15:0]   r_sweep, n_sweep;
    logic [1:0]    r_mode, n_mode;
    logic          r_border, n_border;
    logic          r_valid, n_valid;
    logic          accept;

    assign o_ready      = (r_state == S_IDLE) && !r_valid;
    assign accept       = i_valid && o_ready;
    assign o_valid      = r_valid;
    assign o_done_mode  = r_mode;
    assign o_zero_pot   = (r_mode != pcls_pkg::MODE_READ);
    assign o_zero_field = (r_mode != pcls_pkg::MODE_READ) || r_border;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_row    = r_row;
        n_col    = r_col;
        n_sweep  = r_sweep;
        n_mode   = r_mode;
        n_border = r_border;
        n_valid  = r_valid;
        o_cmd    = '0;
        o_cmd.cur_row = r_row;
        o_cmd.cur_col = r_col;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = i_mode;
                    n_step = '0;
                    if (i_mode == pcls_pkg::MODE_INIT) begin
                        n_row = '0;
                        n_col = '0;
                        n_state = S_INIT;
                    end else if (i_mode == pcls_pkg::MODE_SWEEP) begin
                        n_row = IW'(1);
                        n_col = IW'(1);
                        n_sweep = '0;
                        n_state = (i_sweeps == 16'd0) ? S_DONE : S_SWEEP;
                    end else if (i_mode == pcls_pkg::MODE_READ) begin
                        n_row = i_row;
                        n_col = i_col;
                        n_border = (i_row == '0) || (i_col == '0) ||
                                   (i_row == LAST) || (i_col == LAST);
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                // The grid starts at zero: one write per cell before the first word.
                o_cmd.clear_wr = 1'b1;
                n_col = r_col + 1'b1;
                if (r_col == LAST) begin
                    n_row = r_row + 1'b1;
                    if (r_row == LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_col = r_col + 1'b1;
                if (r_col == LAST) begin
                    n_row = r_row + 1'b1;
                    if (r_row == LAST) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SWEEP: begin
                // Steps 0..3 issue neighbor reads, step 4 takes the last and writes.
                n_step = r_step + 3'd1;
                o_cmd.rd_tag = r_step;
                unique case (r_step)
                    3'd0: begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_addr = {r_row - 1'b1, r_col};
                    end
                    3'd1: begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_addr = {r_row + 1'b1, r_col};
                    end
                    3'd2: begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_addr = {r_row, r_col - 1'b1};
                    end
                    3'd3: begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_addr = {r_row, r_col + 1'b1};
                    end
                    default: begin
                        o_cmd.cell_wr = 1'b1;
                        n_step = '0;
                        n_col = r_col + 1'b1;
                        if (r_col == LAST - 1'b1) begin
                            n_col = IW'(1);
                            n_row = r_row + 1'b1;
                            if (r_row == LAST - 1'b1) begin
                                n_row = IW'(1);
                                n_sweep = r_sweep + 16'd1;
                                if (r_sweep + 16'd1 == i_sweeps) begin
                                    n_state = S_DONE;
                                end
                            end
                        end
                    end
                endcase
            end
            S_READ: begin
                // Five reads at steps 0..4, then steps 5 and 6 let the last data land.
                n_step = r_step + 3'd1;
                o_cmd.rd_tag = r_step;
                o_cmd.mem_rd = (r_step < 3'd5);
                unique case (r_step)
                    3'd0: o_cmd.rd_addr = {r_row - 1'b1, r_col};
                    3'd1: o_cmd.rd_addr = {r_row + 1'b1, r_col};
                    3'd2: o_cmd.rd_addr = {r_row, r_col - 1'b1};
                    3'd3: o_cmd.rd_addr = {r_row, r_col + 1'b1};
                    default: o_cmd.rd_addr = {r_row, r_col};
                endcase
                if (r_step == 3'd6) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_valid) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_step  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_sweep <= '0;
            r_mode  <= '0;
            r_border <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_step  <= n_step;
            r_row   <= n_row;
            r_col   <= n_col;
            r_sweep <= n_sweep;
            r_mode  <= n_mode;
            r_border <= n_border;
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_valid) |=> r_valid) else $error("result lost");
    a_single_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.cell_wr && o_cmd.init_wr)) else $error("double write");
`endif
endmodule

### sv/plate_capacitor_laplace_solver.sv
// Top level of the plate capacitor Laplace solver: configuration registers,
// controller and datapath. Depends on pcls_pkg, pcls_ctrl and pcls_datapath.
//
// Usage: one command word (mode, row, col) enters on the valid/ready input
// channel; exactly one result word leaves on the valid/ready output channel.
// Mode 0 writes every grid cell once. Mode 1 runs sweep_count sweeps; for
// each interior cell it issues four neighbor reads through the single grid
// read port, then the write. Mode 2 reads five cells and computes the field.
// One command is in flight at a time; the next one is taken once the
// previous result has been taken by the receiver. If the receiver stalls,
// the result is held in the output register unchanged.
// Reset returns the registers to their defaults and starts a clearing pass
// that writes zero to every grid cell, during which the input channel is not
// ready. Configuration writes take effect at once; they are to be made while
// idle by the user, as the block itself does not enforce it.
module plate_capacitor_laplace_solver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [8:0]          i_row,
    input  logic [8:0]          i_col,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [23:0]  o_potential,
    output logic signed [31:0]  o_field_x,
    output logic signed [31:0]  o_field_y,
    output logic [1:0]          o_done_mode,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [pcls_pkg::CFG_W-1:0] i_cfg_data
);
    logic [8:0]  r_top_row, r_bot_row, r_first_col, r_last_col;
    logic [22:0] r_half_v;
    logic [15:0] r_sweeps, r_scale;
    pcls_pkg::t_cmd cmd;
    logic signed [23:0] pot;
    logic signed [31:0] fx, fy;
    logic zero_pot, zero_field;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_row   <= 9'd307;
            r_bot_row   <= 9'd205;
            r_first_col <= 9'd155;
            r_last_col  <= 9'd357;
            r_half_v    <= 23'd3276800;
            r_sweeps    <= 16'd5000;
            r_scale     <= 16'd13107;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcls_pkg::REG_TOP_ROW:   r_top_row   <= i_cfg_data[8:0];
                pcls_pkg::REG_BOT_ROW:   r_bot_row   <= i_cfg_data[8:0];
                pcls_pkg::REG_FIRST_COL: r_first_col <= i_cfg_data[8:0];
                pcls_pkg::REG_LAST_COL:  r_last_col  <= i_cfg_data[8:0];
                pcls_pkg::REG_HALF_V:    r_half_v    <= i_cfg_data[22:0];
                pcls_pkg::REG_SWEEPS:    r_sweeps    <= i_cfg_data[15:0];
                pcls_pkg::REG_SCALE:     r_scale     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pcls_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_sweeps     (r_sweeps),
        .o_cmd        (cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_done_mode  (o_done_mode),
        .o_zero_pot   (zero_pot),
        .o_zero_field (zero_field)
    );

    pcls_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_top_row   (r_top_row),
        .i_bot_row   (r_bot_row),
        .i_first_col (r_first_col),
        .i_last_col  (r_last_col),
        .i_half_v    (r_half_v),
        .i_scale     (r_scale),
        .o_pot       (pot),
        .o_fx        (fx),
        .o_fy        (fy)
    );

    assign o_potential = zero_pot   ? '0 : pot;
    assign o_field_x   = zero_field ? '0 : fx;
    assign o_field_y   = zero_field ? '0 : fy;
endmodule

### tb/pcls_result_checker.sv
// Result checker for the plate capacitor solver: watches the command, result and
// register ports, keeps its own copy of the grid and compares every result word.
// Depends on pcls_pkg.
module pcls_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [8:0]         i_row,
    input  logic [8:0]         i_col,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [23:0] o_potential,
    input  logic signed [31:0] o_field_x,
    input  logic signed [31:0] o_field_y,
    input  logic [1:0]         o_done_mode,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [pcls_pkg::CFG_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_SIZE = pcls_pkg::GRID_SIZE;

    typedef struct {
        logic signed [23:0] potential;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic [1:0]         done_mode;
    } t_cell_result;

    t_cell_result cell_results_due[$];
    int           grid[GRID_SIZE*GRID_SIZE];

    logic [8:0]  top_row, bot_row, first_col, last_col;
    logic [22:0] half_volt;
    logic [15:0] sweep_total, scale;

    // 0 for a free cell, 1 for the positive plate, 2 for the negative plate.
    function automatic int plate_of(int r, int c);
        if (c < first_col || c > last_col) return 0;
        if (r == top_row) return 1;
        if (r == bot_row) return 2;
        return 0;
    endfunction

    function automatic int plate_level(int kind);
        return (kind == 1) ? int'(half_volt) : -int'(half_volt);
    endfunction

    function automatic logic signed [31:0] scaled_field(longint diff);
        longint p;
        p = (diff * longint'(scale)) >>> 8;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    task automatic lay_plates();
        int k;
        for (int r = 0; r < GRID_SIZE; r++) begin
            for (int c = 0; c < GRID_SIZE; c++) begin
                k = plate_of(r, c);
                grid[r*GRID_SIZE+c] = k ? plate_level(k) : 0;
            end
        end
    endtask

    // In-place relaxation: cells already visited in this sweep feed the next ones.
    task automatic relax_grid();
        int     k;
        longint sum;
        for (int s = 0; s < sweep_total; s++) begin
            for (int r = 1; r < GRID_SIZE - 1; r++) begin
                for (int c = 1; c < GRID_SIZE - 1; c++) begin
                    k = plate_of(r, c);
                    if (k) begin
                        grid[r*GRID_SIZE+c] = plate_level(k);
                    end else begin
                        sum = longint'(grid[(r+1)*GRID_SIZE+c]) + grid[(r-1)*GRID_SIZE+c]
                            + grid[r*GRID_SIZE+c+1] + grid[r*GRID_SIZE+c-1];
                        grid[r*GRID_SIZE+c] = int'(sum >>> 2);
                    end
                end
            end
        end
    endtask

    task automatic solve_command(input logic [1:0] m, input int r, input int c,
                                 output t_cell_result res);
        res.potential = '0;
        res.field_x   = '0;
        res.field_y   = '0;
        res.done_mode = m;
        if (m == pcls_pkg::MODE_INIT) begin
            lay_plates();
        end else if (m == pcls_pkg::MODE_SWEEP) begin
            relax_grid();
        end else if (m == pcls_pkg::MODE_READ && r < GRID_SIZE && c < GRID_SIZE) begin
            res.potential = 24'(grid[r*GRID_SIZE+c]);
            if (r > 0 && c > 0 && r < GRID_SIZE - 1 && c < GRID_SIZE - 1) begin
                res.field_x = scaled_field(longint'(grid[r*GRID_SIZE+c-1])
                                           - grid[r*GRID_SIZE+c+1]);
                res.field_y = scaled_field(longint'(grid[(r-1)*GRID_SIZE+c])
                                           - grid[(r+1)*GRID_SIZE+c]);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            top_row     = 9'd307;
            bot_row     = 9'd205;
            first_col   = 9'd155;
            last_col    = 9'd357;
            half_volt   = 23'd3276800;
            sweep_total = 16'd5000;
            scale       = 16'd13107;
            cell_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcls_pkg::REG_TOP_ROW:   top_row     = i_cfg_data[8:0];
                    pcls_pkg::REG_BOT_ROW:   bot_row     = i_cfg_data[8:0];
                    pcls_pkg::REG_FIRST_COL: first_col   = i_cfg_data[8:0];
                    pcls_pkg::REG_LAST_COL:  last_col    = i_cfg_data[8:0];
                    pcls_pkg::REG_HALF_V:    half_volt   = i_cfg_data[22:0];
                    pcls_pkg::REG_SWEEPS:    sweep_total = i_cfg_data[15:0];
                    pcls_pkg::REG_SCALE:     scale       = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                solve_command(i_mode, i_row, i_col, want);
                cell_results_due.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (cell_results_due.size() == 0) begin
                    report_mismatch("unexpected word, mode", o_done_mode, -1);
                end else begin
                    want = cell_results_due.pop_front();
                    if (o_done_mode !== want.done_mode)
                        report_mismatch("done_mode", o_done_mode, want.done_mode);
                    if (o_potential !== want.potential)
                        report_mismatch("potential", o_potential, want.potential);
                    if (o_field_x !== want.field_x)
                        report_mismatch("field_x", o_field_x, want.field_x);
                    if (o_field_y !== want.field_y)
                        report_mismatch("field_y", o_field_y, want.field_y);
                end
            end
        end
        o_pending <= cell_results_due.size();
    end

endmodule

### tb/tb_plate_capacitor_laplace_solver.sv
// Testbench top for the plate capacitor solver: clock, reset, register writes and
// command words; results are judged by pcls_result_checker. Depends on pcls_pkg.
module tb_plate_capacitor_laplace_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [1:0]         i_mode = pcls_pkg::MODE_INIT;
    logic [8:0]         i_row = '0;
    logic [8:0]         i_col = '0;
    logic               i_ready = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = pcls_pkg::REG_TOP_ROW;
    logic [pcls_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic               o_ready, o_valid;
    logic signed [23:0] o_potential;
    logic signed [31:0] o_field_x, o_field_y;
    logic [1:0]         o_done_mode;
    int                 fail_count, words_pending;
    int                 send_idle_pct = 11;
    int                 recv_idle_pct = 75;
    int                 cycles = 0;

    plate_capacitor_laplace_solver u_dut (.*);

    pcls_result_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[pcls_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Valid is only lowered when a gap is taken, so back-to-back words keep it high.
    task automatic send_word(input logic [1:0] m, input int r, input int c);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_mode  <= m;
        i_row   <= r[8:0];
        i_col   <= c[8:0];
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_words(input int count);
        int pick, r, c;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_word(pcls_pkg::MODE_SWEEP, $urandom_range(511), $urandom_range(511));
            end else if (pick < 22) begin
                send_word(MODE_UNUSED, $urandom_range(511), $urandom_range(511));
            end else begin
                // Most reads land where the plates and the relaxed cells are.
                if ($urandom_range(99) < 65) begin
                    r = $urandom_range(310, 290);
                    c = $urandom_range(420, 390);
                end else begin
                    r = $urandom_range(511);
                    c = $urandom_range(511);
                end
                send_word(pcls_pkg::MODE_READ, r, c);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Adjacent plates two rows apart at full voltage and full scale saturate the field.
        write_reg(pcls_pkg::REG_SWEEPS, 0);
        write_reg(pcls_pkg::REG_SCALE, 65535);
        write_reg(pcls_pkg::REG_HALF_V, 8388607);
        write_reg(pcls_pkg::REG_TOP_ROW, 12);
        write_reg(pcls_pkg::REG_BOT_ROW, 10);
        write_reg(pcls_pkg::REG_FIRST_COL, 1);
        write_reg(pcls_pkg::REG_LAST_COL, 510);
        send_word(pcls_pkg::MODE_INIT, 0, 0);
        send_word(pcls_pkg::MODE_READ, 11, 5);
        send_word(pcls_pkg::MODE_READ, 12, 0);
        send_word(pcls_pkg::MODE_READ, 12, 510);
        send_word(pcls_pkg::MODE_READ, 10, 511);
        send_word(pcls_pkg::MODE_READ, 0, 0);
        send_word(pcls_pkg::MODE_READ, 511, 511);
        send_word(pcls_pkg::MODE_SWEEP, 0, 0);
        send_word(MODE_UNUSED, 511, 511);
        send_word(pcls_pkg::MODE_READ, 11, 255);
        drain();

        // Plates on the border rows with an empty column span.
        write_reg(pcls_pkg::REG_TOP_ROW, 0);
        write_reg(pcls_pkg::REG_BOT_ROW, 511);
        write_reg(pcls_pkg::REG_FIRST_COL, 200);
        write_reg(pcls_pkg::REG_LAST_COL, 100);
        write_reg(pcls_pkg::REG_HALF_V, 0);
        write_reg(pcls_pkg::REG_SCALE, 0);
        send_word(pcls_pkg::MODE_INIT, 0, 0);
        send_word(pcls_pkg::MODE_READ, 0, 150);
        send_word(pcls_pkg::MODE_READ, 1, 150);
        drain();

        // Overlapping plate rows reaching the border column, then one real sweep.
        write_reg(pcls_pkg::REG_TOP_ROW, 300);
        write_reg(pcls_pkg::REG_BOT_ROW, 300);
        write_reg(pcls_pkg::REG_FIRST_COL, 400);
        write_reg(pcls_pkg::REG_LAST_COL, 511);
        write_reg(pcls_pkg::REG_HALF_V, 3276800);
        write_reg(pcls_pkg::REG_SCALE, 13107);
        write_reg(pcls_pkg::REG_SWEEPS, 1);
        send_word(pcls_pkg::MODE_INIT, 0, 0);
        send_word(pcls_pkg::MODE_SWEEP, 0, 0);
        send_word(pcls_pkg::MODE_READ, 300, 511);
        send_word(pcls_pkg::MODE_READ, 301, 400);
        send_word(pcls_pkg::MODE_READ, 299, 399);
        send_word(pcls_pkg::MODE_READ, 305, 450);
        drain();
        write_reg(pcls_pkg::REG_SWEEPS, 0);

        random_words(33);
        drain();
        write_reg(pcls_pkg::REG_SCALE, $urandom_range(65535));
        send_idle_pct = 75;
        recv_idle_pct = 11;
        random_words(33);
        drain();
        write_reg(pcls_pkg::REG_SCALE, 65535);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_words(34);
        drain();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
